### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define SPHC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property, checked during reset too.
`define SPHC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/sphc_pkg.sv
package sphc_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned WORD_WIDTH      = 32;
   localparam int unsigned BYTE_WIDTH      = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_SEED       = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CRC_POLYNOMIAL = 8'd1;

   localparam logic [WORD_WIDTH-1:0] CRC_SEED_RESET = 32'hEDB8_8320;
   localparam logic [WORD_WIDTH-1:0] CRC_POLY_RESET = 32'hEDB8_8320;
   localparam logic [WORD_WIDTH-1:0] HEX_SATURATED  = 32'hFFFF_FFFF;

   localparam logic [BYTE_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UP_F  = 8'h46;
   localparam logic [BYTE_WIDTH-1:0] CHAR_UP_X  = 8'h58;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LO_F  = 8'h66;
   localparam logic [BYTE_WIDTH-1:0] CHAR_LO_X  = 8'h78;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_DIGITS = 2'd3;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] hash_value;
      logic                  from_hex_literal;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_digit(input logic [BYTE_WIDTH-1:0] b);
      hex_digit_type d;
      d.ok    = 1'b1;
      d.value = 4'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         d.value = 4'(b - CHAR_ZERO);
      end else if (b >= CHAR_LO_A && b <= CHAR_LO_F) begin
         d.value = 4'(b - CHAR_LO_A + 8'd10);
      end else if (b >= CHAR_UP_A && b <= CHAR_UP_F) begin
         d.value = 4'(b - CHAR_UP_A + 8'd10);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] crc_byte(input logic [WORD_WIDTH-1:0] crc,
                                                      input logic [BYTE_WIDTH-1:0] b,
                                                      input logic [WORD_WIDTH-1:0] poly);
      logic [WORD_WIDTH-1:0] c;
      c = crc ^ {{(WORD_WIDTH-BYTE_WIDTH){1'b0}}, b};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

### src/string_plug_hash_crc32_unit.sv
// Name hash unit: takes one character per item, one item per clock while
// req_stall is low. A zero byte ends the name and produces one result: the
// reflected CRC-32 of the name (start value csr register 0, polynomial csr
// register 1, no final inversion), 0 for an empty name, or the parsed value
// of a "0x"/"0X" hex literal (saturated at 0xFFFFFFFF, rsp_from_hex_literal
// set). The result enters the output stage when the zero byte is taken.
// The byte-wise CRC runs as eight bit steps on the running register.
// Results go through a two-entry output stage, so req_stall rises only
// while both entries hold results the consumer has not taken. csr_ready is
// always high; writes to unknown indexes are dropped. A seed write applies
// from the next name, a polynomial write from the next character.
module string_plug_hash_crc32_unit
   import sphc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [BYTE_WIDTH-1:0]      req_text_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [WORD_WIDTH-1:0]      rsp_hash_value,
   output logic                       rsp_from_hex_literal,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data
);

   logic [WORD_WIDTH-1:0] seed_ff, seed_in;
   logic [WORD_WIDTH-1:0] poly_ff, poly_in;
   logic [WORD_WIDTH-1:0] crc_ff, crc_in;
   logic [WORD_WIDTH-1:0] hex_ff, hex_in;
   logic [1:0]            pos_ff, pos_in;
   logic                  hex_ok_ff, hex_ok_in;
   logic                  ovf_ff, ovf_in;

   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic          accept;
   logic          is_end;
   logic          res_push;
   logic          out_free;
   result_type    res;
   hex_digit_type digit;
   logic [WORD_WIDTH-1:0] crc_start;

   assign csr_ready            = 1'b1;
   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_hash_value       = out_ff.hash_value;
   assign rsp_from_hex_literal = out_ff.from_hex_literal;

   assign accept   = req_valid && !req_stall;
   assign is_end   = (req_text_byte == CHAR_NUL);
   assign res_push = accept && is_end;
   assign out_free = !out_valid_ff || !rsp_stall;
   assign digit    = hex_digit(req_text_byte);
   assign crc_start = (pos_ff == POS_FIRST) ? seed_ff : crc_ff;

   always_comb begin
      seed_in = seed_ff;
      poly_in = poly_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CRC_SEED:       seed_in = csr_data;
            CSR_CRC_POLYNOMIAL: poly_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      res.hash_value       = crc_ff;
      res.from_hex_literal = 1'b0;
      if (pos_ff == POS_FIRST) begin
         res.hash_value = '0;
      end else if (hex_ok_ff && pos_ff == POS_DIGITS) begin
         res.hash_value       = ovf_ff ? HEX_SATURATED : hex_ff;
         res.from_hex_literal = 1'b1;
      end
   end

   always_comb begin
      crc_in    = crc_ff;
      hex_in    = hex_ff;
      pos_in    = pos_ff;
      hex_ok_in = hex_ok_ff;
      ovf_in    = ovf_ff;
      if (accept) begin
         if (is_end) begin
            crc_in    = '0;
            hex_in    = '0;
            pos_in    = POS_FIRST;
            hex_ok_in = 1'b1;
            ovf_in    = 1'b0;
         end else begin
            crc_in = crc_byte(crc_start, req_text_byte, poly_ff);
            if (hex_ok_ff) begin
               if (pos_ff == POS_FIRST) begin
                  if (req_text_byte != CHAR_ZERO) hex_ok_in = 1'b0;
               end else if (pos_ff == POS_SECOND) begin
                  if (req_text_byte != CHAR_LO_X && req_text_byte != CHAR_UP_X) begin
                     hex_ok_in = 1'b0;
                  end
               end else if (!digit.ok) begin
                  hex_ok_in = 1'b0;
               end else if (!ovf_ff) begin
                  if (hex_ff[WORD_WIDTH-1 -: 4] != 4'd0) begin
                     ovf_in = 1'b1;
                  end else begin
                     hex_in = {hex_ff[WORD_WIDTH-5:0], digit.value};
                  end
               end
            end
            if (pos_ff != POS_DIGITS) pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = res;
            out_valid_in = res_push;
         end
      end else if (res_push) begin
         skid_in       = res;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= CRC_SEED_RESET;
         poly_ff       <= CRC_POLY_RESET;
         pos_ff        <= POS_FIRST;
         hex_ok_ff     <= 1'b1;
         ovf_ff        <= 1'b0;
         hex_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         seed_ff       <= seed_in;
         poly_ff       <= poly_in;
         pos_ff        <= pos_in;
         hex_ok_ff     <= hex_ok_in;
         ovf_ff        <= ovf_in;
         hex_ff        <= hex_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

### src/sphc_checker.sv
`include "assert_macros.svh"

module sphc_checker
   import sphc_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [BYTE_WIDTH-1:0]      req_text_byte,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [WORD_WIDTH-1:0]      rsp_hash_value,
   input logic                       rsp_from_hex_literal
);

   logic end_taken;
   logic rsp_idle;
   logic rsp_held;
   assign end_taken = req_valid && !req_stall && (req_text_byte == CHAR_NUL);
   assign rsp_idle  = !rsp_valid && !end_taken;
   assign rsp_held  = rsp_valid && rsp_stall;

   `SPHC_ASSERT_ALWAYS(a_reset_no_rsp, clock, reset |=> !rsp_valid, "item after reset")

   `SPHC_ASSERT(a_no_spurious_rsp, clock, reset,
                rsp_idle |=> !rsp_valid, "item without terminator")

   `SPHC_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid, "stalled item dropped")

   `SPHC_ASSERT(a_rsp_stable, clock, reset,
                rsp_held |=> $stable(rsp_hash_value) && $stable(rsp_from_hex_literal),
                "stalled item changed")

endmodule

bind string_plug_hash_crc32_unit sphc_checker u_sphc_checker (.*);

### bench/string_plug_hash_crc32_unit_tb.sv
module string_plug_hash_crc32_unit_tb;
   import sphc_pkg::*;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] ch;
      logic                  typed;
      logic [WORD_WIDTH-1:0] hash;
      logic                  hex;
   } text_row_type;

   localparam int DIRECTED_ROWS = 27;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [BYTE_WIDTH-1:0]      req_text_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [WORD_WIDTH-1:0]      rsp_hash_value;
   logic                       rsp_from_hex_literal;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]      csr_data = '0;

   // name hash predictor state
   logic [WORD_WIDTH-1:0] seed_reg = CRC_SEED_RESET;
   logic [WORD_WIDTH-1:0] poly_reg = CRC_POLY_RESET;
   logic [WORD_WIDTH-1:0] crc_acc  = CRC_SEED_RESET;
   logic [WORD_WIDTH-1:0] hex_acc  = '0;
   logic [1:0]            name_pos = POS_FIRST;
   logic                  hex_ok   = 1'b1;
   logic                  hex_ovf  = 1'b0;

   result_type hash_expected [$];

   int fail_count   = 0;
   int bytes_sent   = 0;
   int names_seen   = 0;
   int hex_seen     = 0;
   int burst_left   = 0;
   int stall_cycle  = 0;
   int settings     = 1;
   bit gaps_on      = 1'b1;

   text_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CHAR_NUL,   1'b1, 32'h0, 1'b0},
      '{CHAR_ZERO,  1'b0, 32'h0, 1'b0},
      '{CHAR_UP_X,  1'b0, 32'h0, 1'b0},
      '{CHAR_ZERO,  1'b0, 32'h0, 1'b0},
      '{CHAR_NUL,   1'b1, 32'h0, 1'b1},
      '{CHAR_ZERO,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_X,  1'b0, 32'h0, 1'b0},
      '{CHAR_NUL,   1'b0, 32'h0, 1'b0},
      '{CHAR_ZERO,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_X,  1'b0, 32'h0, 1'b0},
      '{CHAR_NINE,  1'b0, 32'h0, 1'b0},
      '{8'hFF,      1'b0, 32'h0, 1'b0},
      '{CHAR_NUL,   1'b0, 32'h0, 1'b0},
      '{8'h01,      1'b0, 32'h0, 1'b0},
      '{CHAR_NUL,   1'b0, 32'h0, 1'b0},
      '{CHAR_ZERO,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_X,  1'b0, 32'h0, 1'b0},
      '{CHAR_UP_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_LO_F,  1'b0, 32'h0, 1'b0},
      '{CHAR_ZERO,  1'b0, 32'h0, 1'b0},
      '{CHAR_NUL,   1'b1, HEX_SATURATED, 1'b1}
   };

   string_plug_hash_crc32_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_text_byte        (req_text_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_hash_value       (rsp_hash_value),
      .rsp_from_hex_literal (rsp_from_hex_literal),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int hex_value_of(input logic [BYTE_WIDTH-1:0] ch);
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) return int'(ch - CHAR_ZERO);
      if (ch >= CHAR_LO_A && ch <= CHAR_LO_F) return int'(ch - CHAR_LO_A) + 10;
      if (ch >= CHAR_UP_A && ch <= CHAR_UP_F) return int'(ch - CHAR_UP_A) + 10;
      return -1;
   endfunction

   function automatic void clear_name();
      crc_acc  = seed_reg;
      hex_acc  = '0;
      name_pos = POS_FIRST;
      hex_ok   = 1'b1;
      hex_ovf  = 1'b0;
   endfunction

   // returns 1 when the character ends a name, with its hash in res
   function automatic bit name_hash_char(input logic [BYTE_WIDTH-1:0] ch,
                                         output result_type res);
      logic [WORD_WIDTH-1:0] c;
      int digit;
      res = '0;
      if (ch == CHAR_NUL) begin
         if (name_pos == POS_FIRST) begin
            res.hash_value = '0;
         end else if (hex_ok && name_pos == POS_DIGITS) begin
            res.hash_value       = hex_ovf ? HEX_SATURATED : hex_acc;
            res.from_hex_literal = 1'b1;
         end else begin
            res.hash_value = crc_acc;
         end
         clear_name();
         return 1'b1;
      end
      if (name_pos == POS_FIRST) crc_acc = seed_reg;
      c = crc_acc ^ {{(WORD_WIDTH-BYTE_WIDTH){1'b0}}, ch};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         if (c[0]) c = (c >> 1) ^ poly_reg;
         else c = c >> 1;
      end
      crc_acc = c;
      if (hex_ok) begin
         if (name_pos == POS_FIRST) begin
            if (ch != CHAR_ZERO) hex_ok = 1'b0;
         end else if (name_pos == POS_SECOND) begin
            if (ch != CHAR_LO_X && ch != CHAR_UP_X) hex_ok = 1'b0;
         end else begin
            digit = hex_value_of(ch);
            if (digit < 0) begin
               hex_ok = 1'b0;
            end else if (!hex_ovf) begin
               if (hex_acc[31:28] != 4'd0) hex_ovf = 1'b1;
               else hex_acc = {hex_acc[27:0], 4'(digit)};
            end
         end
      end
      if (name_pos != POS_DIGITS) name_pos = name_pos + 2'd1;
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] ch, input logic typed,
                            input result_type typed_res);
      int gap;
      result_type res;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0 || !gaps_on) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_text_byte <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (name_hash_char(ch, res)) begin
         if (typed) hash_expected.push_back(typed_res);
         else hash_expected.push_back(res);
      end
   endtask

   function automatic logic [BYTE_WIDTH-1:0] pick_digit_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return CHAR_ZERO + 8'(v);
      if ($urandom_range(0, 1) == 0) return CHAR_LO_A + 8'(v - 10);
      return CHAR_UP_A + 8'(v - 10);
   endfunction

   function automatic logic [BYTE_WIDTH-1:0] pick_text_char(input bit no_hex);
      logic [BYTE_WIDTH-1:0] ch;
      ch = 8'($urandom_range(1, 255));
      while (no_hex && hex_value_of(ch) >= 0) ch = 8'($urandom_range(1, 255));
      return ch;
   endfunction

   task automatic send_name(input bit terminate);
      logic [BYTE_WIDTH-1:0] name_q [$];
      int kind;
      int n;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         name_q.push_back(CHAR_ZERO);
         name_q.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
      end
      if (kind <= 3) begin
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n) name_q.push_back(CHAR_ZERO);
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         repeat (n) name_q.push_back(pick_digit_char());
      end else if (kind == 4) begin
         n = $urandom_range(0, 3);
         repeat (n) name_q.push_back(pick_digit_char());
         name_q.push_back(pick_text_char(1'b1));
         n = $urandom_range(0, 2);
         repeat (n) name_q.push_back(pick_digit_char());
      end else if (kind == 5) begin
         name_q.push_back(CHAR_ZERO);
         case ($urandom_range(0, 2))
            0: name_q.push_back($urandom_range(0, 1) ? CHAR_LO_X : CHAR_UP_X);
            1: ;
            default: name_q.push_back(pick_text_char(1'b0));
         endcase
      end else begin
         n = $urandom_range(0, 12);
         if (n != 0 && $urandom_range(0, 3) == 0) name_q.push_back(CHAR_ZERO);
         repeat (n) name_q.push_back(pick_text_char(1'b0));
      end
      if (terminate) name_q.push_back(CHAR_NUL);
      foreach (name_q[i]) send_byte(name_q[i], 1'b0, '0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [WORD_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_CRC_SEED) seed_reg = data;
      else if (index == CSR_CRC_POLYNOMIAL) poly_reg = data;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (hash_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic random_names(input int budget);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < budget) send_name(1'b1);
      // leave a name open so the next settings land mid-name
      if ($urandom_range(0, 1) == 0) send_name(1'b0);
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (hash_expected.size() == 0) begin
            $error("unexpected hash result %h hex %0b", rsp_hash_value, rsp_from_hex_literal);
            fail_count++;
         end else begin
            want = hash_expected.pop_front();
            names_seen++;
            if (want.from_hex_literal) hex_seen++;
            if (rsp_hash_value !== want.hash_value) begin
               $error("hash_value expected %h actual %h", want.hash_value, rsp_hash_value);
               fail_count++;
            end
            if (rsp_from_hex_literal !== want.from_hex_literal) begin
               $error("from_hex_literal expected %0b actual %0b",
                      want.from_hex_literal, rsp_from_hex_literal);
               fail_count++;
            end
         end
      end
      stall_cycle++;
      case (stall_cycle[10:9])
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= stall_cycle[3] & stall_cycle[2];
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_byte(directed_rows[i].ch, directed_rows[i].typed,
                   '{hash_value: directed_rows[i].hash,
                     from_hex_literal: directed_rows[i].hex});
      random_names(300);
      settle();

      write_reg(CSR_CRC_SEED, '0);
      write_reg(CSR_CRC_POLYNOMIAL, '0);
      csr_valid <= 1'b0;
      settings++;
      random_names(300);
      settle();

      write_reg(CSR_CRC_SEED, HEX_SATURATED);
      write_reg(CSR_CRC_POLYNOMIAL, HEX_SATURATED);
      csr_valid <= 1'b0;
      settings++;
      random_names(300);
      settle();

      write_reg(CSR_CRC_SEED, $urandom());
      write_reg(CSR_CRC_POLYNOMIAL, $urandom());
      write_reg(8'd2, $urandom());
      write_reg(8'hFF, $urandom());
      csr_valid <= 1'b0;
      settings++;
      random_names(300);
      settle();

      write_reg(CSR_CRC_SEED, HEX_SATURATED);
      write_reg(CSR_CRC_POLYNOMIAL, CRC_POLY_RESET);
      csr_valid <= 1'b0;
      settings++;
      gaps_on = 1'b0;
      random_names(200);
      gaps_on = 1'b1;
      send_name(1'b1);
      random_names(150);
      settle();

      repeat (8) @(posedge clock);
      $display("Sent %0d text bytes under %0d register settings,", bytes_sent, settings);
      $display("checked %0d names, %0d of them hex literals.", names_seen, hex_seen);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
